### rtl/core/llsim_pkg.sv
// Shared types and constants for the lag-loop second-order simulator.
// Holds fixed-point widths, configuration defaults, and the command struct
// that links the controller to the datapath. No dependencies.
package llsim_pkg;

    // Fixed-point format and counter width.
    localparam int INDEX_BITS = 20;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 31;
    localparam int DT_W       = 17;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int RND_W      = PROD_W - FRAC_BITS;
    localparam int ACC_W      = RND_W + 2;

    // Rounding and reference constants.
    localparam logic signed [PROD_W-1:0] Q_HALF = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0]  Q_ONE  = ACC_W'(64'sd1 <<< FRAC_BITS);

    // The settling band is 2% of the final value: 50 * |y - f| <= |f|.
    localparam int SETTLE_RATIO = 50;
    localparam int SETTLE_W     = DATA_W + 1 + 6;

    // Configuration port.
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STIFFNESS     = 3'd0,
        CFG_DAMPING       = 3'd1,
        CFG_INPUT_GAIN    = 3'd2,
        CFG_POLE          = 3'd3,
        CFG_STATE_GAIN    = 3'd4,
        CFG_DIRECT_GAIN   = 3'd5,
        CFG_TIME_STEP     = 3'd6,
        CFG_SETTLE_TARGET = 3'd7
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [COEF_W-1:0]        RST_STIFFNESS     = 31'd65536;
    localparam logic [COEF_W-1:0]        RST_DAMPING       = 31'd65536;
    localparam logic signed [DATA_W-1:0] RST_INPUT_GAIN    = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_POLE          = -32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_STATE_GAIN    = 32'sd0;
    localparam logic signed [DATA_W-1:0] RST_DIRECT_GAIN   = 32'sd65536;
    localparam logic [DT_W-1:0]          RST_TIME_STEP     = 17'd655;
    localparam logic signed [DATA_W-1:0] RST_SETTLE_TARGET = 32'sd32768;

    typedef struct packed {
        logic [COEF_W-1:0]        stiffness;
        logic [COEF_W-1:0]        damping;
        logic signed [DATA_W-1:0] input_gain;
        logic signed [DATA_W-1:0] pole;
        logic signed [DATA_W-1:0] state_gain;
        logic signed [DATA_W-1:0] direct_gain;
        logic [DT_W-1:0]          time_step;
        logic signed [DATA_W-1:0] settle_target;
    } cfg_t;

    // Operand pairs for the shared multiplier.
    typedef enum logic [3:0] {
        MUL_SGAIN_Z,
        MUL_DGAIN_E,
        MUL_POLE_Z,
        MUL_STIFF_POS,
        MUL_DAMP_VEL,
        MUL_GAIN_U,
        MUL_VEL_DT,
        MUL_D2_DT,
        MUL_DZ_DT
    } mul_sel_t;

    // Accumulator operations on the rounded product.
    typedef enum logic [3:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_LOAD_NEG,
        ACC_LOAD_E,
        ACC_ADD,
        ACC_SUB,
        ACC_STEP_POS,
        ACC_STEP_VEL,
        ACC_STEP_Z
    } acc_op_t;

    // Where the saturated sum is stored.
    typedef enum logic [2:0] {
        DST_NONE,
        DST_U,
        DST_DZ,
        DST_D2,
        DST_POS,
        DST_VEL,
        DST_Z
    } dst_t;

    typedef struct packed {
        logic     start;
        logic     sample;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        dst_t     dst;
        logic     finish;
    } cmd_t;

endpackage

### rtl/core/llsim_cfg.sv
// Configuration register bank for the lag-loop simulator.
// Depends on llsim_pkg for register indexes, reset values and cfg_t.
module llsim_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [llsim_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [llsim_pkg::DATA_W-1:0]        cfg_data,
    output llsim_pkg::cfg_t                     cfg
);

    llsim_pkg::cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register bank with decoded write strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stiffness     <= llsim_pkg::RST_STIFFNESS;
            cfg_reg.damping       <= llsim_pkg::RST_DAMPING;
            cfg_reg.input_gain    <= llsim_pkg::RST_INPUT_GAIN;
            cfg_reg.pole          <= llsim_pkg::RST_POLE;
            cfg_reg.state_gain    <= llsim_pkg::RST_STATE_GAIN;
            cfg_reg.direct_gain   <= llsim_pkg::RST_DIRECT_GAIN;
            cfg_reg.time_step     <= llsim_pkg::RST_TIME_STEP;
            cfg_reg.settle_target <= llsim_pkg::RST_SETTLE_TARGET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (llsim_pkg::cfg_reg_t'(cfg_index))
                llsim_pkg::CFG_STIFFNESS:
                    cfg_reg.stiffness <= cfg_data[llsim_pkg::COEF_W-1:0];
                llsim_pkg::CFG_DAMPING:
                    cfg_reg.damping <= cfg_data[llsim_pkg::COEF_W-1:0];
                llsim_pkg::CFG_INPUT_GAIN:
                    cfg_reg.input_gain <= $signed(cfg_data);
                llsim_pkg::CFG_POLE:
                    cfg_reg.pole <= $signed(cfg_data);
                llsim_pkg::CFG_STATE_GAIN:
                    cfg_reg.state_gain <= $signed(cfg_data);
                llsim_pkg::CFG_DIRECT_GAIN:
                    cfg_reg.direct_gain <= $signed(cfg_data);
                llsim_pkg::CFG_TIME_STEP:
                    cfg_reg.time_step <= cfg_data[llsim_pkg::DT_W-1:0];
                llsim_pkg::CFG_SETTLE_TARGET:
                    cfg_reg.settle_target <= $signed(cfg_data);
            endcase
        end
    end

endmodule

### rtl/core/llsim_dp.sv
// Datapath of the lag-loop simulator: loop states, metrics, one shared
// multiplier with a rounding accumulator, and the result register.
// Depends on llsim_pkg for widths, cfg_t and the command struct.
module llsim_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  llsim_pkg::cfg_t                        cfg,
    input  llsim_pkg::cmd_t                        cmd,
    input  logic                                   restart,
    input  logic                                   last_tick,
    output logic [llsim_pkg::INDEX_BITS-1:0]       tick_index,
    output logic signed [llsim_pkg::DATA_W-1:0]    plant_output,
    output logic signed [llsim_pkg::DATA_W-1:0]    loop_error,
    output logic signed [llsim_pkg::DATA_W-1:0]    control_value,
    output logic [llsim_pkg::COEF_W-1:0]           peak_value,
    output logic                                   peak_valid,
    output logic [llsim_pkg::INDEX_BITS-1:0]       peak_index,
    output logic                                   settle_valid,
    output logic [llsim_pkg::INDEX_BITS-1:0]       settle_index,
    output logic                                   run_done
);

    localparam int DW = llsim_pkg::DATA_W;
    localparam int AW = llsim_pkg::ACC_W;
    localparam int IW = llsim_pkg::INDEX_BITS;
    localparam int SW = llsim_pkg::SETTLE_W;

    // Clamp a wide sum to the signed 32-bit range.
    function automatic logic signed [DW-1:0] sat32(input logic signed [AW-1:0] v);
        logic [AW-DW:0] top;
        top = v[AW-1:DW-1];
        if (top == '0 || top == '1)
            return v[DW-1:0];
        else if (v[AW-1])
            return {1'b1, {(DW-1){1'b0}}};
        else
            return {1'b0, {(DW-1){1'b1}}};
    endfunction

    // Loop state and run metrics.
    logic signed [DW-1:0] pos_reg, vel_reg, z_reg;
    logic [IW-1:0]        cnt_reg;
    logic signed [DW-1:0] peak_reg;
    logic [IW-1:0]        peak_tick_reg, settle_tick_reg;
    logic                 peak_seen_reg, settle_seen_reg;
    logic                 last_reg;

    // Per-tick working values.
    logic signed [DW-1:0] y_reg, e_reg, u_reg, d2_reg, dz_reg;
    logic [IW-1:0]        idx_reg;
    logic signed [llsim_pkg::PROD_W-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;

    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [llsim_pkg::PROD_W-1:0] prod_next, prod_rnd_full;
    logic signed [llsim_pkg::RND_W-1:0] rnd;
    logic signed [AW-1:0] term, sum;
    logic signed [DW-1:0] sum_sat, e_next;
    logic signed [DW:0]   diff;
    logic [DW:0]          abs_diff;
    logic [DW-1:0]        abs_target;
    logic [SW-1:0]        band_scaled;
    logic                 in_band, new_peak, clear_run;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (cmd.mul_sel)
            llsim_pkg::MUL_SGAIN_Z:
            begin
                mul_a = cfg.state_gain;
                mul_b = z_reg;
            end
            llsim_pkg::MUL_DGAIN_E:
            begin
                mul_a = cfg.direct_gain;
                mul_b = e_reg;
            end
            llsim_pkg::MUL_POLE_Z:
            begin
                mul_a = cfg.pole;
                mul_b = z_reg;
            end
            llsim_pkg::MUL_STIFF_POS:
            begin
                mul_a = $signed({1'b0, cfg.stiffness});
                mul_b = pos_reg;
            end
            llsim_pkg::MUL_DAMP_VEL:
            begin
                mul_a = $signed({1'b0, cfg.damping});
                mul_b = vel_reg;
            end
            llsim_pkg::MUL_GAIN_U:
            begin
                mul_a = cfg.input_gain;
                mul_b = u_reg;
            end
            llsim_pkg::MUL_VEL_DT:
            begin
                mul_a = vel_reg;
                mul_b = $signed({{(DW-llsim_pkg::DT_W){1'b0}}, cfg.time_step});
            end
            llsim_pkg::MUL_D2_DT:
            begin
                mul_a = d2_reg;
                mul_b = $signed({{(DW-llsim_pkg::DT_W){1'b0}}, cfg.time_step});
            end
            llsim_pkg::MUL_DZ_DT:
            begin
                mul_a = dz_reg;
                mul_b = $signed({{(DW-llsim_pkg::DT_W){1'b0}}, cfg.time_step});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Round half up, then drop the fraction bits.
    assign prod_rnd_full = prod_reg + llsim_pkg::Q_HALF;
    assign rnd  = $signed(prod_rnd_full[llsim_pkg::PROD_W-1:llsim_pkg::FRAC_BITS]);
    assign term = {{(AW-llsim_pkg::RND_W){rnd[llsim_pkg::RND_W-1]}}, rnd};

    // Accumulator adder.
    always_comb
    begin
        unique case (cmd.acc_op)
            llsim_pkg::ACC_HOLD:     sum = acc_reg;
            llsim_pkg::ACC_LOAD:     sum = term;
            llsim_pkg::ACC_LOAD_NEG: sum = -term;
            llsim_pkg::ACC_LOAD_E:   sum = AW'(e_reg) + term;
            llsim_pkg::ACC_ADD:      sum = acc_reg + term;
            llsim_pkg::ACC_SUB:      sum = acc_reg - term;
            llsim_pkg::ACC_STEP_POS: sum = AW'(pos_reg) + term;
            llsim_pkg::ACC_STEP_VEL: sum = AW'(vel_reg) + term;
            llsim_pkg::ACC_STEP_Z:   sum = AW'(z_reg) + term;
            default:                 sum = acc_reg;
        endcase
    end

    assign sum_sat = sat32(sum);

    // Error against the unit step, from the current position.
    assign e_next = sat32(llsim_pkg::Q_ONE - AW'(pos_reg));

    // Settling band test, exact: 50 * |y - f| <= |f|.
    assign diff        = $signed({pos_reg[DW-1], pos_reg})
                         - $signed({cfg.settle_target[DW-1], cfg.settle_target});
    assign abs_diff    = diff[DW] ? (DW+1)'(-diff) : diff;
    assign abs_target  = cfg.settle_target[DW-1] ? (~cfg.settle_target + 1'b1)
                                                 : cfg.settle_target;
    assign band_scaled = SW'(abs_diff) * SW'(llsim_pkg::SETTLE_RATIO);
    assign in_band     = band_scaled <= SW'(abs_target);
    assign new_peak    = pos_reg > peak_reg;

    // A run is cleared before a restart tick and after a last tick.
    assign clear_run = (cmd.start && restart) || (cmd.finish && last_reg);

    // Loop state, counter and metrics.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            vel_reg         <= '0;
            z_reg           <= '0;
            cnt_reg         <= '0;
            peak_reg        <= '0;
            peak_tick_reg   <= '0;
            peak_seen_reg   <= 1'b0;
            settle_tick_reg <= '0;
            settle_seen_reg <= 1'b0;
        end
        else if (clear_run)
        begin
            pos_reg         <= '0;
            vel_reg         <= '0;
            z_reg           <= '0;
            cnt_reg         <= '0;
            peak_reg        <= '0;
            peak_tick_reg   <= '0;
            peak_seen_reg   <= 1'b0;
            settle_tick_reg <= '0;
            settle_seen_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sample && new_peak)
            begin
                peak_reg      <= pos_reg;
                peak_tick_reg <= cnt_reg;
                peak_seen_reg <= 1'b1;
            end
            if (cmd.sample && !settle_seen_reg && in_band)
            begin
                settle_seen_reg <= 1'b1;
                settle_tick_reg <= cnt_reg;
            end
            if (cmd.dst == llsim_pkg::DST_POS)
                pos_reg <= sum_sat;
            if (cmd.dst == llsim_pkg::DST_VEL)
                vel_reg <= sum_sat;
            if (cmd.dst == llsim_pkg::DST_Z)
                z_reg <= sum_sat;
            if (cmd.finish)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Per-tick working registers and the multiplier pipeline.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
            last_reg <= last_tick;
        if (cmd.sample)
        begin
            y_reg   <= pos_reg;
            e_reg   <= e_next;
            idx_reg <= cnt_reg;
        end
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.acc_op != llsim_pkg::ACC_HOLD)
            acc_reg <= sum;
        if (cmd.dst == llsim_pkg::DST_U)
            u_reg <= sum_sat;
        if (cmd.dst == llsim_pkg::DST_D2)
            d2_reg <= sum_sat;
        if (cmd.dst == llsim_pkg::DST_DZ)
            dz_reg <= sum_sat;
    end

    // Result register, loaded as the tick retires.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            tick_index    <= idx_reg;
            plant_output  <= y_reg;
            loop_error    <= e_reg;
            control_value <= u_reg;
            peak_value    <= peak_reg[llsim_pkg::COEF_W-1:0];
            peak_valid    <= peak_seen_reg;
            peak_index    <= peak_tick_reg;
            settle_valid  <= settle_seen_reg;
            settle_index  <= settle_tick_reg;
            run_done      <= last_reg;
        end
    end

endmodule

### rtl/core/llsim_ctrl.sv
// Sequencer of the lag-loop simulator: steps the shared multiplier through
// one tick and owns the input and result handshakes.
// Depends on llsim_pkg for the command struct and its enums.
module llsim_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output llsim_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_M7,
        ST_M8,
        ST_M9,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Command decode: M1-M9 issue a product each, M2-FIN fold in the one before.
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = llsim_pkg::MUL_SGAIN_Z;
        cmd.acc_op  = llsim_pkg::ACC_HOLD;
        cmd.dst     = llsim_pkg::DST_NONE;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.start = in_valid;
                if (in_valid)
                    state_next = ST_M1;
            end
            ST_M1:
            begin
                cmd.sample  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = llsim_pkg::MUL_SGAIN_Z;
                state_next  = ST_M2;
            end
            ST_M2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = llsim_pkg::MUL_DGAIN_E;
                cmd.acc_op  = llsim_pkg::ACC_LOAD;
                state_next  = ST_M3;
            end
            ST_M3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = llsim_pkg::MUL_POLE_Z;
                cmd.acc_op  = llsim_pkg::ACC_ADD;
                cmd.dst     = llsim_pkg::DST_U;
                state_next  = ST_M4;
            end
            ST_M4:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = llsim_pkg::MUL_STIFF_POS;
                cmd.acc_op  = llsim_pkg::ACC_LOAD_E;
                cmd.dst     = llsim_pkg::DST_DZ;
                state_next  = ST_M5;
            end
            ST_M5:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = llsim_pkg::MUL_DAMP_VEL;
                cmd.acc_op  = llsim_pkg::ACC_LOAD_NEG;
                state_next  = ST_M6;
            end
            ST_M6:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = llsim_pkg::MUL_GAIN_U;
                cmd.acc_op  = llsim_pkg::ACC_SUB;
                state_next  = ST_M7;
            end
            ST_M7:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = llsim_pkg::MUL_VEL_DT;
                cmd.acc_op  = llsim_pkg::ACC_ADD;
                cmd.dst     = llsim_pkg::DST_D2;
                state_next  = ST_M8;
            end
            ST_M8:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = llsim_pkg::MUL_D2_DT;
                cmd.acc_op  = llsim_pkg::ACC_STEP_POS;
                cmd.dst     = llsim_pkg::DST_POS;
                state_next  = ST_M9;
            end
            ST_M9:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = llsim_pkg::MUL_DZ_DT;
                cmd.acc_op  = llsim_pkg::ACC_STEP_VEL;
                cmd.dst     = llsim_pkg::DST_VEL;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                // Retire only once the result register can take the item.
                if (out_free)
                begin
                    cmd.acc_op = llsim_pkg::ACC_STEP_Z;
                    cmd.dst    = llsim_pkg::DST_Z;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted item always starts the multiply sequence.
    a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_M1))
        else $error("accepted item did not start the sequence");

    // A retired tick always leaves a result on the output.
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("retired tick produced no result");

    // A tick waits in its last step while the result register is full.
    a_fin_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_valid_reg && !out_ready) |=> (state_reg == ST_FIN))
        else $error("tick retired over a pending result");

    // The multiplier and state writes are quiet while idle.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!cmd.mul_en && cmd.dst == llsim_pkg::DST_NONE))
        else $error("datapath active while idle");

endmodule

### rtl/core/lag_loop_second_order_sim_top.sv
// Nine products pass in turn through one 32x32 multiplier, between an accept
//   step and a retire step; a new item is taken only after the last retires.
// A result still waiting holds the next item in its last step until taken.
// Reset (rst_n low, asynchronous): loop states, counter and metrics clear to
//   zero and the configuration registers return to their defaults.
module lag_loop_second_order_sim_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [llsim_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [llsim_pkg::DATA_W-1:0]           cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   restart,
    input  logic                                   last_tick,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [llsim_pkg::INDEX_BITS-1:0]       tick_index,
    output logic signed [llsim_pkg::DATA_W-1:0]    plant_output,
    output logic signed [llsim_pkg::DATA_W-1:0]    loop_error,
    output logic signed [llsim_pkg::DATA_W-1:0]    control_value,
    output logic [llsim_pkg::COEF_W-1:0]           peak_value,
    output logic                                   peak_valid,
    output logic [llsim_pkg::INDEX_BITS-1:0]       peak_index,
    output logic                                   settle_valid,
    output logic [llsim_pkg::INDEX_BITS-1:0]       settle_index,
    output logic                                   run_done
);

    llsim_pkg::cfg_t cfg;
    llsim_pkg::cmd_t cmd;

    // Configuration registers.
    llsim_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer.
    llsim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Datapath.
    llsim_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .restart       (restart),
        .last_tick     (last_tick),
        .tick_index    (tick_index),
        .plant_output  (plant_output),
        .loop_error    (loop_error),
        .control_value (control_value),
        .peak_value    (peak_value),
        .peak_valid    (peak_valid),
        .peak_index    (peak_index),
        .settle_valid  (settle_valid),
        .settle_index  (settle_index),
        .run_done      (run_done)
    );

endmodule

### bench/loop_step_checker.sv
`timescale 1ns / 100ps
// Checker for the lag-loop simulator: follows the register, tick and result channels,
// runs its own fixed-point copy of the closed loop and compares every result item.
// Depends on llsim_pkg for widths and register codes.
module loop_step_checker
    import llsim_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]            cfg_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         restart,
    input  logic                         last_tick,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [INDEX_BITS-1:0]        tick_index,
    input  logic signed [DATA_W-1:0]     plant_output,
    input  logic signed [DATA_W-1:0]     loop_error,
    input  logic signed [DATA_W-1:0]     control_value,
    input  logic [COEF_W-1:0]            peak_value,
    input  logic                         peak_valid,
    input  logic [INDEX_BITS-1:0]        peak_index,
    input  logic                         settle_valid,
    input  logic [INDEX_BITS-1:0]        settle_index,
    input  logic                         run_done,
    output int                           fail_count,
    output int                           pending
);

    localparam longint S32_MAX  = 64'sd2147483647;
    localparam longint S32_MIN  = -64'sd2147483648;
    localparam longint Q_UNIT   = longint'(1) <<< FRAC_BITS;
    localparam longint Q_ROUND  = longint'(1) <<< (FRAC_BITS - 1);

    typedef struct packed {
        logic [INDEX_BITS-1:0]    tick_index;
        logic signed [DATA_W-1:0] plant_output;
        logic signed [DATA_W-1:0] loop_error;
        logic signed [DATA_W-1:0] control_value;
        logic [COEF_W-1:0]        peak_value;
        logic                     peak_valid;
        logic [INDEX_BITS-1:0]    peak_index;
        logic                     settle_valid;
        logic [INDEX_BITS-1:0]    settle_index;
        logic                     run_done;
    } tick_result_t;

    // Register copies.
    logic [COEF_W-1:0]        stiffness_r;
    logic [COEF_W-1:0]        damping_r;
    logic signed [DATA_W-1:0] input_gain_r;
    logic signed [DATA_W-1:0] pole_r;
    logic signed [DATA_W-1:0] state_gain_r;
    logic signed [DATA_W-1:0] direct_gain_r;
    logic [DT_W-1:0]          dt_r;
    logic signed [DATA_W-1:0] final_r;

    // Loop states and run metrics.
    logic signed [DATA_W-1:0] pos_r;
    logic signed [DATA_W-1:0] vel_r;
    logic signed [DATA_W-1:0] integ_r;
    logic signed [DATA_W-1:0] peak_r;
    logic [INDEX_BITS-1:0]    tick_r;
    logic [INDEX_BITS-1:0]    peak_tick_r;
    logic [INDEX_BITS-1:0]    settle_tick_r;
    logic                     peak_seen_r;
    logic                     settle_seen_r;

    tick_result_t predicted_ticks[$];
    int           mismatches;

    assign fail_count = mismatches;

    function automatic longint sat32(longint v);
        if (v > S32_MAX)
        begin
            return S32_MAX;
        end
        if (v < S32_MIN)
        begin
            return S32_MIN;
        end
        return v;
    endfunction

    // Exact product scaled back with round half up; >>> on a signed value is a floor.
    function automatic longint qmul(longint a, longint b);
        return (a * b + Q_ROUND) >>> FRAC_BITS;
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void clear_run();
        pos_r         = '0;
        vel_r         = '0;
        integ_r       = '0;
        tick_r        = '0;
        peak_r        = '0;
        peak_tick_r   = '0;
        peak_seen_r   = 1'b0;
        settle_tick_r = '0;
        settle_seen_r = 1'b0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        case (cfg_reg_t'(idx))
            CFG_STIFFNESS:     stiffness_r   = data[COEF_W-1:0];
            CFG_DAMPING:       damping_r     = data[COEF_W-1:0];
            CFG_INPUT_GAIN:    input_gain_r  = data;
            CFG_POLE:          pole_r        = data;
            CFG_STATE_GAIN:    state_gain_r  = data;
            CFG_DIRECT_GAIN:   direct_gain_r = data;
            CFG_TIME_STEP:     dt_r          = data[DT_W-1:0];
            CFG_SETTLE_TARGET: final_r       = data;
            default: ;
        endcase
    endfunction

    // One tick: report the loop before the update, then take one Euler step.
    function automatic tick_result_t predict_tick(logic rs, logic lt);
        tick_result_t r;
        longint       y;
        longint       e;
        longint       u;
        longint       d2;
        longint       dz;
        longint       fv;
        if (rs)
        begin
            clear_run();
        end
        y  = pos_r;
        fv = final_r;
        e  = sat32(Q_UNIT - y);
        u  = sat32(qmul(state_gain_r, integ_r) + qmul(direct_gain_r, e));

        // The peak moves only on a strictly larger output.
        if (y > longint'(peak_r))
        begin
            peak_r      = pos_r;
            peak_tick_r = tick_r;
            peak_seen_r = 1'b1;
        end
        // First entry into the 2% band, exact integer test.
        if (!settle_seen_r && (SETTLE_RATIO * magnitude(y - fv) <= magnitude(fv)))
        begin
            settle_seen_r = 1'b1;
            settle_tick_r = tick_r;
        end

        r.tick_index    = tick_r;
        r.plant_output  = pos_r;
        r.loop_error    = e[DATA_W-1:0];
        r.control_value = u[DATA_W-1:0];
        r.peak_value    = peak_r[COEF_W-1:0];
        r.peak_valid    = peak_seen_r;
        r.peak_index    = peak_tick_r;
        r.settle_valid  = settle_seen_r;
        r.settle_index  = settle_tick_r;
        r.run_done      = lt;

        d2 = sat32(-qmul(stiffness_r, pos_r) - qmul(damping_r, vel_r)
                   + qmul(input_gain_r, u));
        dz = sat32(qmul(pole_r, integ_r) + e);

        pos_r   = DATA_W'(sat32(longint'(pos_r) + qmul(vel_r, dt_r)));
        vel_r   = DATA_W'(sat32(longint'(vel_r) + qmul(d2, dt_r)));
        integ_r = DATA_W'(sat32(longint'(integ_r) + qmul(dz, dt_r)));
        tick_r  = tick_r + 1'b1;

        if (lt)
        begin
            clear_run();
        end
        return r;
    endfunction

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Sample all three channels at the clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_r   = RST_STIFFNESS;
            damping_r     = RST_DAMPING;
            input_gain_r  = RST_INPUT_GAIN;
            pole_r        = RST_POLE;
            state_gain_r  = RST_STATE_GAIN;
            direct_gain_r = RST_DIRECT_GAIN;
            dt_r          = RST_TIME_STEP;
            final_r       = RST_SETTLE_TARGET;
            clear_run();
            predicted_ticks.delete();
            mismatches    = 0;
            pending      <= 0;
        end
        else
        begin
            tick_result_t want;
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
            end
            // Results are matched before this edge's item is queued.
            if (out_valid && out_ready)
            begin
                if (predicted_ticks.size() == 0)
                begin
                    $error("result item with no tick waiting, tick_index %0d", tick_index);
                    mismatches++;
                end
                else
                begin
                    want = predicted_ticks.pop_front();
                    compare_field("tick_index", want.tick_index, tick_index);
                    compare_field("plant_output", $signed(want.plant_output),
                                  plant_output);
                    compare_field("loop_error", $signed(want.loop_error), loop_error);
                    compare_field("control_value", $signed(want.control_value),
                                  control_value);
                    compare_field("peak_value", want.peak_value, peak_value);
                    compare_field("peak_valid", want.peak_valid, peak_valid);
                    compare_field("peak_index", want.peak_index, peak_index);
                    compare_field("settle_valid", want.settle_valid, settle_valid);
                    compare_field("settle_index", want.settle_index, settle_index);
                    compare_field("run_done", want.run_done, run_done);
                end
            end
            if (in_valid && in_ready)
            begin
                predicted_ticks.push_back(predict_tick(restart, last_tick));
            end
            pending <= predicted_ticks.size();
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Top of the lag-loop simulator bench: clock, reset, register loads, tick stimulus
// and the verdict. Depends on llsim_pkg, lag_loop_second_order_sim_top and loop_step_checker.
module testbench;
    import llsim_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     restart;
    logic                     last_tick;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [INDEX_BITS-1:0]    tick_index;
    logic signed [DATA_W-1:0] plant_output;
    logic signed [DATA_W-1:0] loop_error;
    logic signed [DATA_W-1:0] control_value;
    logic [COEF_W-1:0]        peak_value;
    logic                     peak_valid;
    logic [INDEX_BITS-1:0]    peak_index;
    logic                     settle_valid;
    logic [INDEX_BITS-1:0]    settle_index;
    logic                     run_done;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          stall_left  = 0;
    bit          calm        = 1'b0;
    logic [31:0] reg_vals [8];

    lag_loop_second_order_sim_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .restart       (restart),
        .last_tick     (last_tick),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tick_index    (tick_index),
        .plant_output  (plant_output),
        .loop_error    (loop_error),
        .control_value (control_value),
        .peak_value    (peak_value),
        .peak_valid    (peak_valid),
        .peak_index    (peak_index),
        .settle_valid  (settle_valid),
        .settle_index  (settle_index),
        .run_done      (run_done)
    );

    loop_step_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .restart       (restart),
        .last_tick     (last_tick),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tick_index    (tick_index),
        .plant_output  (plant_output),
        .loop_error    (loop_error),
        .control_value (control_value),
        .peak_value    (peak_value),
        .peak_valid    (peak_valid),
        .peak_index    (peak_index),
        .settle_valid  (settle_valid),
        .settle_index  (settle_index),
        .run_done      (run_done),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Mostly short idle gaps, a few long ones, none in calm stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    function automatic real frand(real lo, real hi);
        return lo + (hi - lo) * ($urandom_range(0, 1000000) / 1.0e6);
    endfunction

    function automatic logic [31:0] to_q(real x);
        return 32'($rtoi(x * 65536.0));
    endfunction

    // A plausible plant and lag compensator, with the band mostly centered on the
    // steady-state output; a flipped pole sign gives an unstable compensator.
    function automatic void pick_plant_config(bit flip_pole);
        real wn2;
        real zeta;
        real gain;
        real beta;
        real tconst;
        real kc;
        real dc;
        wn2    = frand(0.25, 4.0);
        zeta   = frand(0.1, 1.2);
        gain   = frand(0.5, 3.0);
        beta   = frand(2.0, 10.0);
        tconst = frand(0.5, 5.0);
        kc     = frand(0.5, 4.0);
        dc     = gain * (kc / beta + kc * (beta - 1.0) * tconst);
        reg_vals[CFG_STIFFNESS]     = to_q(wn2);
        reg_vals[CFG_DAMPING]       = to_q(2.0 * zeta * $sqrt(wn2));
        reg_vals[CFG_INPUT_GAIN]    = to_q(gain * wn2);
        reg_vals[CFG_POLE]          = to_q((flip_pole ? 1.0 : -1.0) / (beta * tconst));
        reg_vals[CFG_STATE_GAIN]    = to_q(kc * (beta - 1.0) / beta);
        reg_vals[CFG_DIRECT_GAIN]   = to_q(kc / beta);
        reg_vals[CFG_TIME_STEP]     = to_q(frand(0.03, 0.1));
        reg_vals[CFG_SETTLE_TARGET] = ($urandom_range(0, 9) < 8) ? to_q(dc / (1.0 + dc))
                                                                  : $urandom;
    endfunction

    function automatic void pick_default_config();
        reg_vals[CFG_STIFFNESS]     = 32'(RST_STIFFNESS);
        reg_vals[CFG_DAMPING]       = 32'(RST_DAMPING);
        reg_vals[CFG_INPUT_GAIN]    = RST_INPUT_GAIN;
        reg_vals[CFG_POLE]          = RST_POLE;
        reg_vals[CFG_STATE_GAIN]    = RST_STATE_GAIN;
        reg_vals[CFG_DIRECT_GAIN]   = RST_DIRECT_GAIN;
        reg_vals[CFG_TIME_STEP]     = 32'(RST_TIME_STEP);
        reg_vals[CFG_SETTLE_TARGET] = RST_SETTLE_TARGET;
    endfunction

    function automatic void pick_edge_config(bit upper);
        reg_vals[CFG_STIFFNESS]     = upper ? 32'h7FFF_FFFF : 32'h0;
        reg_vals[CFG_DAMPING]       = upper ? 32'h7FFF_FFFF : 32'h0;
        reg_vals[CFG_INPUT_GAIN]    = upper ? 32'h7FFF_FFFF : 32'h8000_0000;
        reg_vals[CFG_POLE]          = upper ? 32'h0 : 32'h8000_0000;
        reg_vals[CFG_STATE_GAIN]    = upper ? 32'h7FFF_FFFF : 32'h8000_0000;
        reg_vals[CFG_DIRECT_GAIN]   = upper ? 32'h7FFF_FFFF : 32'h8000_0000;
        reg_vals[CFG_TIME_STEP]     = upper ? 32'd65536 : 32'd1;
        reg_vals[CFG_SETTLE_TARGET] = upper ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    // Writes all registers back to back; called only with nothing in flight.
    task automatic load_registers();
        for (int i = 0; i < $size(reg_vals); i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= reg_vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Offers one tick item, holds it until accepted, then maybe idles.
    task automatic send_tick(bit rs, bit lt);
        int gap;
        in_valid  <= 1'b1;
        restart   <= rs;
        last_tick <= lt;
        do @(posedge clk); while (!in_ready);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering items and waits until every predicted result is taken.
    task automatic settle_out();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Mostly whole runs ending in last_tick, sometimes with a restart; the rest is noise.
    // A run is cut short so that the phase sends exactly item_count items.
    task automatic drive_runs(int item_count);
        int sent;
        int run_len;
        bit fresh;
        sent = 0;
        while (sent < item_count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                      : $urandom_range(1, 120);
                if (run_len > item_count - sent)
                begin
                    run_len = item_count - sent;
                end
                fresh   = 1'($urandom_range(0, 1));
                for (int k = 0; k < run_len; k++)
                begin
                    send_tick((k == 0 && fresh) || ($urandom_range(0, 199) == 0),
                              k == run_len - 1);
                    sent++;
                end
            end
            else
            begin
                run_len = $urandom_range(1, 6);
                if (run_len > item_count - sent)
                begin
                    run_len = item_count - sent;
                end
                repeat (run_len)
                begin
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
        settle_out();
    endtask

    task automatic run_phase(int item_count, bit quiet);
        calm <= quiet;
        load_registers();
        drive_runs(item_count);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STIFFNESS;
        cfg_data  = '0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        last_tick = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults from reset: plain ticks, a mid-run restart, end of run,
        // a fresh run after it, and restart together with last_tick.
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        settle_out();

        // Zero final value: the band is a single point, met at the first tick.
        pick_default_config();
        reg_vals[CFG_SETTLE_TARGET] = '0;
        load_registers();
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        settle_out();

        // Zero time step: the states hold still and the peak never moves.
        reg_vals[CFG_TIME_STEP] = '0;
        load_registers();
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        settle_out();

        // Register extremes, upper set then lower set, drive the wide sums into saturation.
        pick_edge_config(1'b1);
        load_registers();
        repeat (3) send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        settle_out();
        pick_edge_config(1'b0);
        load_registers();
        repeat (3) send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        settle_out();

        // Random runs under a series of settings.
        pick_edge_config(1'b1);
        run_phase(60, 1'b0);
        pick_edge_config(1'b0);
        run_phase(60, 1'b1);
        pick_default_config();
        reg_vals[CFG_TIME_STEP] = '0;
        run_phase(40, 1'b0);
        pick_plant_config(1'b1);
        run_phase(60, 1'b0);
        for (int p = 0; p < 8; p++)
        begin
            pick_plant_config(1'b0);
            run_phase(120, p % 3 == 2);
        end
        for (int p = 0; p < 3; p++)
        begin
            foreach (reg_vals[i])
            begin
                reg_vals[i] = $urandom;
            end
            run_phase(60, 1'b0);
        end
        pick_default_config();
        run_phase(90, 1'b0);

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
